@@ hdl/nce_pkg.sv @@
// Package for the noise channel: configuration indexes, fixed widths,
// sequencer states and the structs passed between the channel modules.
// No dependencies.
package nce_pkg;

    localparam int unsigned CPU_HZ_DEF    = 16780000;
    localparam int unsigned STEP_BITS_DEF = 12;

    localparam int unsigned BASE_FAST = 1048576;
    localparam int unsigned BASE_SLOW = 524288;
    localparam int unsigned LEN_STEPS = 64;
    localparam int unsigned LEN_DIV   = 256;

    localparam int unsigned LFSR_W  = 15;
    localparam int unsigned ENV_W   = 24;
    localparam int unsigned LEN_W   = 23;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned DATA_W  = 24;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h4000;
    localparam logic [LFSR_W-1:0] TAP_WIDE  = 15'h6000;
    localparam logic [LFSR_W-1:0] TAP_SHORT = 15'h0060;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 23'h7FFFFF;

    localparam logic [IDX_W-1:0] CFG_DIVIDE_RATIO    = 8'd0;
    localparam logic [IDX_W-1:0] CFG_SHIFT_CLOCK     = 8'd1;
    localparam logic [IDX_W-1:0] CFG_WIDE_MODE       = 8'd2;
    localparam logic [IDX_W-1:0] CFG_ENVELOPE_PERIOD = 8'd3;
    localparam logic [IDX_W-1:0] CFG_ENVELOPE_UP     = 8'd4;
    localparam logic [IDX_W-1:0] CFG_LENGTH_ENABLE   = 8'd5;
    localparam logic [IDX_W-1:0] CFG_SOUND_LENGTH    = 8'd6;
    localparam logic [IDX_W-1:0] CFG_START_VOLUME    = 8'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_ENV_CHK,
        S_ENV_DIV,
        S_ENV_APPLY,
        S_LEN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             wide_mode;
        logic [ENV_W-1:0] envelope_period;
        logic             envelope_up;
        logic             length_enable;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic wide;
    } t_lfsr_ctl;

endpackage

@@ hdl/nce_alu.sv @@
// Shared subtract and compare unit of the noise channel sequencer.
// Depends on nothing but its width parameter.
module nce_alu #(
    parameter int unsigned W = 25
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

@@ hdl/nce_lfsr.sv @@
// 15-bit noise shift register with selectable feedback tap and last carry.
// Depends on nce_pkg.
module nce_lfsr (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nce_pkg::t_lfsr_ctl              i_ctl,
    output logic                            o_out_bit
);

    logic [nce_pkg::LFSR_W-1:0] r_lfsr;
    logic [nce_pkg::LFSR_W-1:0] n_lfsr;
    logic [nce_pkg::LFSR_W-1:0] w_tap;
    logic                       r_out_bit;

    always_comb begin
        w_tap  = i_ctl.wide ? nce_pkg::TAP_WIDE : nce_pkg::TAP_SHORT;
        n_lfsr = {1'b0, r_lfsr[nce_pkg::LFSR_W-1:1]};
        if (r_lfsr[0]) begin
            n_lfsr = n_lfsr ^ w_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr    <= nce_pkg::LFSR_SEED;
            r_out_bit <= 1'b0;
        end else if (i_ctl.shift) begin
            r_lfsr    <= n_lfsr;
            r_out_bit <= r_lfsr[0];
        end
    end

    assign o_out_bit = r_out_bit;

endmodule

@@ hdl/nce_seq.sv @@
// Sequencer of the noise channel: accumulators, envelope division, length
// check and the result register. Depends on nce_pkg, nce_alu and nce_lfsr.
module nce_seq #(
    parameter int unsigned STEP_BITS = nce_pkg::STEP_BITS_DEF,
    parameter int unsigned PW        = 25,
    parameter int unsigned TW        = 23
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nce_pkg::t_cfg              i_cfg,
    input  logic [PW-1:0]              i_period,
    input  logic [TW-1:0]              i_thresh,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [STEP_BITS-1:0]       i_step_cycles,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [7:0]          o_sample,
    output logic                       o_active,
    output logic                       o_noise_bit
);

    localparam int unsigned SAW = ((PW > STEP_BITS) ? PW : STEP_BITS) + 1;
    localparam int unsigned EAW = ((nce_pkg::ENV_W > STEP_BITS) ?
                                   nce_pkg::ENV_W : STEP_BITS) + 1;
    localparam int unsigned LSW = ((nce_pkg::LEN_W > STEP_BITS) ?
                                   nce_pkg::LEN_W : STEP_BITS) + 1;
    localparam int unsigned AW0 = (SAW > EAW) ? SAW : EAW;
    localparam int unsigned AW1 = (AW0 > TW) ? AW0 : TW;
    localparam int unsigned AW  = (AW1 > nce_pkg::LEN_W) ? AW1 : nce_pkg::LEN_W;
    localparam int unsigned CW  = $clog2(EAW);

    nce_pkg::t_state r_state;
    nce_pkg::t_state n_state;

    logic [SAW-1:0]            r_sacc,   n_sacc;
    logic [EAW-1:0]            r_eacc,   n_eacc;
    logic [EAW-1:0]            r_rem,    n_rem;
    logic [nce_pkg::LEN_W-1:0] r_lacc,   n_lacc;
    logic [PW-1:0]             r_period, n_period;
    logic [TW-1:0]             r_thresh, n_thresh;
    logic [CW-1:0]             r_cnt,    n_cnt;
    logic [4:0]                r_quot,   n_quot;
    logic [3:0]                r_vol,    n_vol;
    logic                      r_silent, n_silent;
    logic                      r_out_valid, n_out_valid;
    logic signed [7:0]         r_sample, n_sample;
    logic                      r_active, n_active;
    logic                      r_noise,  n_noise;

    logic [AW-1:0]             w_a;
    logic [AW-1:0]             w_b;
    logic                      w_ge;
    logic [AW-1:0]             w_diff;
    logic [EAW-1:0]            w_trial;
    logic [5:0]                w_qx;
    logic [4:0]                w_vsum;
    logic [LSW-1:0]            w_lsum;
    logic [6:0]                w_mag;
    logic                      w_accept;
    logic                      w_out_bit;
    nce_pkg::t_lfsr_ctl        w_lctl;

    nce_alu #(
        .W (AW)
    ) u_alu (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    nce_lfsr u_lfsr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_lctl),
        .o_out_bit (w_out_bit)
    );

    assign o_stall  = (r_state != nce_pkg::S_IDLE) || !i_rst_n;
    assign w_accept = i_valid && !o_stall;
    assign w_trial  = {r_rem[EAW-2:0], r_eacc[EAW-1]};
    assign w_qx     = {r_quot, w_ge};
    assign w_vsum   = {1'b0, r_vol} + r_quot;
    assign w_lsum   = LSW'(r_lacc) + LSW'(i_step_cycles);
    assign w_mag    = {r_vol, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nce_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sacc      = r_sacc;
        n_eacc      = r_eacc;
        n_rem       = r_rem;
        n_lacc      = r_lacc;
        n_period    = r_period;
        n_thresh    = r_thresh;
        n_cnt       = r_cnt;
        n_quot      = r_quot;
        n_vol       = r_vol;
        n_silent    = r_silent;
        n_out_valid = r_out_valid && i_stall;
        n_sample    = r_sample;
        n_active    = r_active;
        n_noise     = r_noise;
        w_a         = '0;
        w_b         = '0;
        w_lctl.shift = 1'b0;
        w_lctl.wide  = i_cfg.wide_mode;

        case (r_state)
            nce_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_sacc   = r_sacc + SAW'(i_step_cycles);
                    n_period = i_period;
                    n_thresh = i_thresh;
                    if (i_cfg.envelope_period != '0) begin
                        n_eacc = r_eacc + EAW'(i_step_cycles);
                    end
                    if (i_cfg.length_enable) begin
                        n_lacc = (w_lsum > LSW'(nce_pkg::LEN_MAX)) ?
                                 nce_pkg::LEN_MAX : w_lsum[nce_pkg::LEN_W-1:0];
                    end
                    n_state = nce_pkg::S_SHIFT;
                end
            end
            nce_pkg::S_SHIFT: begin
                w_a = AW'(r_sacc);
                w_b = AW'(r_period);
                if (w_ge) begin
                    n_sacc       = w_diff[SAW-1:0];
                    w_lctl.shift = 1'b1;
                end else begin
                    n_state = nce_pkg::S_ENV_CHK;
                end
            end
            nce_pkg::S_ENV_CHK: begin
                w_a = AW'(r_eacc);
                w_b = AW'(i_cfg.envelope_period);
                n_rem  = '0;
                n_quot = '0;
                n_cnt  = CW'(EAW - 1);
                if ((i_cfg.envelope_period != '0) && w_ge) begin
                    n_state = nce_pkg::S_ENV_DIV;
                end else begin
                    n_state = nce_pkg::S_LEN;
                end
            end
            nce_pkg::S_ENV_DIV: begin
                w_a    = AW'(w_trial);
                w_b    = AW'(i_cfg.envelope_period);
                n_rem  = w_ge ? w_diff[EAW-1:0] : w_trial;
                n_quot = (w_qx >= 6'd16) ? 5'd16 : w_qx[4:0];
                n_eacc = {r_eacc[EAW-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_eacc  = n_rem;
                    n_state = nce_pkg::S_ENV_APPLY;
                end
            end
            nce_pkg::S_ENV_APPLY: begin
                if (i_cfg.envelope_up) begin
                    n_vol = (w_vsum >= 5'd15) ? 4'd15 : w_vsum[3:0];
                end else begin
                    n_vol = (r_quot >= {1'b0, r_vol}) ? 4'd0 : r_vol - r_quot[3:0];
                end
                n_state = nce_pkg::S_LEN;
            end
            nce_pkg::S_LEN: begin
                w_a      = AW'(r_lacc);
                w_b      = AW'(r_thresh);
                n_silent = i_cfg.length_enable && w_ge;
                n_state  = nce_pkg::S_OUT;
            end
            nce_pkg::S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_active    = !r_silent;
                    n_noise     = w_out_bit;
                    if (r_silent) begin
                        n_sample = '0;
                    end else if (w_out_bit) begin
                        n_sample = signed'({1'b0, w_mag});
                    end else begin
                        n_sample = signed'(8'd0 - {1'b0, w_mag});
                    end
                    n_state = nce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sacc      <= '0;
            r_eacc      <= '0;
            r_lacc      <= '0;
            r_vol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sacc      <= n_sacc;
            r_eacc      <= n_eacc;
            r_lacc      <= n_lacc;
            r_vol       <= n_vol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_period <= n_period;
        r_thresh <= n_thresh;
        r_cnt    <= n_cnt;
        r_quot   <= n_quot;
        r_silent <= n_silent;
        r_sample <= n_sample;
        r_active <= n_active;
        r_noise  <= n_noise;
    end

    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;
    assign o_active    = r_active;
    assign o_noise_bit = r_noise;

endmodule

@@ hdl/noise_channel_lfsr_envelope.sv @@
// Top level of the noise channel: configuration registers, shift period and
// length limit tables, sequencer. Depends on nce_pkg and nce_seq.
//
// Use: the input channel (i_valid, o_stall, i_step_cycles) takes one beat per
// step, giving the CPU time elapsed. Each beat yields one result beat on
// the output channel (o_valid, i_stall) with o_sample, o_active, o_noise_bit.
// Configuration is written through i_cfg_valid / o_cfg_ready with a register
// index and data; write only while no beat is in flight.
// Sequence: from accept, the sequencer makes the LFSR shifts due in that
// step (one shift per cycle through the shared subtractor), then checks the
// envelope, runs the bit-serial envelope division when at least one envelope
// period elapses, checks the length limit and registers the result.
// A new beat is taken only after the last one leaves the sequencer; o_stall is
// high while a beat is worked on.
// Reset: synchronous; clears the channel state, the LFSR to its seed and the
// configuration registers to their reset values. o_stall and o_cfg_ready hold off in reset.
// Receiver stall: the result register holds its beat; the next beat can be
// accepted and worked on, and waits at its end until the register is free.
module noise_channel_lfsr_envelope #(
    parameter int unsigned CPU_HZ    = nce_pkg::CPU_HZ_DEF,
    parameter int unsigned STEP_BITS = nce_pkg::STEP_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [STEP_BITS-1:0]          i_step_cycles,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [7:0]             o_sample,
    output logic                          o_active,
    output logic                          o_noise_bit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nce_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [nce_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned PW = $clog2(CPU_HZ + 1);
    localparam int unsigned TW = $clog2(CPU_HZ / 4 + 1);

    logic [2:0]                r_divide_ratio;
    logic [3:0]                r_shift_clock;
    logic                      r_wide_mode;
    logic [nce_pkg::ENV_W-1:0] r_envelope_period;
    logic                      r_envelope_up;
    logic                      r_length_enable;
    logic [5:0]                r_sound_length;

    logic [PW-1:0]             w_period_tab [8][16];
    logic [TW-1:0]             w_thresh_tab [64];
    logic [PW-1:0]             w_period;
    logic [TW-1:0]             w_thresh;
    nce_pkg::t_cfg             w_cfg;

    for (genvar r = 0; r < 8; r++) begin : g_ratio
        localparam longint unsigned BASE = (r == 0) ? longint'(nce_pkg::BASE_FAST) :
                                           longint'(nce_pkg::BASE_SLOW) /
                                           ((r == 0) ? 1 : r);
        for (genvar s = 0; s < 16; s++) begin : g_shift
            localparam longint unsigned FRQ_RAW = BASE >> (s + 1);
            localparam longint unsigned FRQ     = (FRQ_RAW == 0) ? 1 : FRQ_RAW;
            localparam longint unsigned PER_RAW = longint'(CPU_HZ) / FRQ;
            localparam longint unsigned PER     = (PER_RAW == 0) ? 1 : PER_RAW;
            assign w_period_tab[r][s] = PW'(PER);
        end
    end

    for (genvar k = 0; k < 64; k++) begin : g_len
        localparam longint unsigned THR = (longint'(nce_pkg::LEN_STEPS - k) *
                                           longint'(CPU_HZ)) / nce_pkg::LEN_DIV;
        assign w_thresh_tab[k] = TW'(THR);
    end

    assign w_period = w_period_tab[r_divide_ratio][r_shift_clock];
    assign w_thresh = w_thresh_tab[r_sound_length];

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_ratio    <= '0;
            r_shift_clock     <= '0;
            r_wide_mode       <= 1'b1;
            r_envelope_period <= '0;
            r_envelope_up     <= 1'b0;
            r_length_enable   <= 1'b0;
            r_sound_length    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nce_pkg::CFG_DIVIDE_RATIO:    r_divide_ratio    <= i_cfg_data[2:0];
                nce_pkg::CFG_SHIFT_CLOCK:     r_shift_clock     <= i_cfg_data[3:0];
                nce_pkg::CFG_WIDE_MODE:       r_wide_mode       <= i_cfg_data[0];
                nce_pkg::CFG_ENVELOPE_PERIOD: r_envelope_period <= i_cfg_data;
                nce_pkg::CFG_ENVELOPE_UP:     r_envelope_up     <= i_cfg_data[0];
                nce_pkg::CFG_LENGTH_ENABLE:   r_length_enable   <= i_cfg_data[0];
                nce_pkg::CFG_SOUND_LENGTH:    r_sound_length    <= i_cfg_data[5:0];
                nce_pkg::CFG_START_VOLUME: begin
                    // volume reloads to zero at every reset
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.wide_mode       = r_wide_mode;
        w_cfg.envelope_period = r_envelope_period;
        w_cfg.envelope_up     = r_envelope_up;
        w_cfg.length_enable   = r_length_enable;
    end

    nce_seq #(
        .STEP_BITS (STEP_BITS),
        .PW        (PW),
        .TW        (TW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_period      (w_period),
        .i_thresh      (w_thresh),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_step_cycles (i_step_cycles),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .o_active      (o_active),
        .o_noise_bit   (o_noise_bit)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted without going busy");

    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without an item in flight");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_sample == 8'sd0)
        else $error("silenced channel gives nonzero sample");

    a_sample_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sample[2:0] == 3'b000)
        else $error("sample not a multiple of eight");

endmodule

@@ test/noise_channel_lfsr_envelope_tb.sv @@
// Testbench for noise_channel_lfsr_envelope: directed and random step beats,
// with results checked against a local model of the LFSR, envelope and length.
// Depends on nce_pkg and the noise_channel_lfsr_envelope RTL.
`timescale 1ns / 100ps

module noise_channel_lfsr_envelope_tb;

    typedef logic [nce_pkg::STEP_BITS_DEF-1:0] t_steps;
    typedef logic [nce_pkg::DATA_W-1:0]        t_data;
    typedef logic [nce_pkg::IDX_W-1:0]         t_idx;

    localparam int unsigned    CYCLE_LIMIT  = 2000000;
    localparam int unsigned    DRAIN_CYCLES = 200;
    localparam int unsigned    HOLD_CYCLES  = 400;
    localparam int unsigned    ITEM_TARGET  = 750;
    localparam t_idx           CFG_FIRST_UNUSED = 8'd8;
    localparam t_idx           CFG_LAST_UNUSED  = 8'hFF;

    typedef struct packed {
        logic signed [7:0] sample;
        logic              active;
        logic              noise_bit;
    } t_sample_beat;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic                     o_stall;
    t_steps                   i_step_cycles = '0;
    logic                     o_valid;
    logic                     i_stall       = 1'b0;
    logic signed [7:0]        o_sample;
    logic                     o_active;
    logic                     o_noise_bit;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    t_idx                     i_cfg_index   = '0;
    t_data                    i_cfg_data    = '0;

    // channel model: registers and state
    logic [2:0]                 cfg_ratio;
    logic [3:0]                 cfg_shift;
    logic                       cfg_wide;
    logic [nce_pkg::ENV_W-1:0]  cfg_env_period;
    logic                       cfg_env_up;
    logic                       cfg_len_en;
    logic [5:0]                 cfg_len;
    logic [3:0]                 cfg_start_vol;
    logic [nce_pkg::LFSR_W-1:0] lfsr_q;
    logic                       noise_q;
    longint unsigned            shift_acc;
    longint unsigned            env_acc;
    longint unsigned            volume_q;
    longint unsigned            len_acc;

    t_sample_beat expected_samples[$];
    int unsigned  fail_count   = 0;
    int unsigned  cycle_count  = 0;
    int unsigned  items_sent   = 0;
    int unsigned  stall_left   = 0;
    int unsigned  hold_left    = 0;
    bit           gaps_off     = 1'b0;
    bit           stalls_off   = 1'b0;
    bit           hold_off_req = 1'b0;

    noise_channel_lfsr_envelope DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_step_cycles(i_step_cycles),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample),
        .o_active     (o_active),
        .o_noise_bit  (o_noise_bit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left != 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (stall_left != 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            if (!stalls_off && $urandom_range(99) < 30)
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_sample_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: result beat with none expected: sample %0d active %0b noise %0b",
                         $time, o_sample, o_active, o_noise_bit);
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_sample !== want.sample) begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, want.sample, o_sample);
                    fail_count++;
                end
                if (o_active !== want.active) begin
                    $display("%0t: active expected %0b actual %0b",
                             $time, want.active, o_active);
                    fail_count++;
                end
                if (o_noise_bit !== want.noise_bit) begin
                    $display("%0t: noise_bit expected %0b actual %0b",
                             $time, want.noise_bit, o_noise_bit);
                    fail_count++;
                end
            end
        end
    end

    function automatic void reset_channel();
        cfg_ratio      = '0;
        cfg_shift      = '0;
        cfg_wide       = 1'b1;
        cfg_env_period = '0;
        cfg_env_up     = 1'b0;
        cfg_len_en     = 1'b0;
        cfg_len        = '0;
        cfg_start_vol  = '0;
        lfsr_q         = nce_pkg::LFSR_SEED;
        noise_q        = 1'b0;
        shift_acc      = 0;
        env_acc        = 0;
        volume_q       = 0;
        len_acc        = 0;
    endfunction

    function automatic t_sample_beat advance_channel(input t_steps steps);
        longint unsigned base, freq, period, eacc, n, limit;
        logic            carry;
        logic [7:0]      mag;
        t_sample_beat    beat;
        base = 64'((cfg_ratio == 0) ? nce_pkg::BASE_FAST : nce_pkg::BASE_SLOW / cfg_ratio);
        freq = base >> (cfg_shift + 1);
        if (freq == 0)
            freq = 1;
        period = nce_pkg::CPU_HZ_DEF / freq;
        if (period == 0)
            period = 1;
        shift_acc += 64'(steps);
        while (shift_acc >= period) begin
            carry  = lfsr_q[0];
            lfsr_q = lfsr_q >> 1;
            if (carry)
                lfsr_q ^= cfg_wide ? nce_pkg::TAP_WIDE : nce_pkg::TAP_SHORT;
            noise_q   = carry;
            shift_acc -= period;
        end
        if (cfg_env_period != 0) begin
            eacc    = env_acc + 64'(steps);
            n       = eacc / cfg_env_period;
            env_acc = eacc % cfg_env_period;
            if (cfg_env_up)
                volume_q = (n >= 15 - volume_q) ? 15 : volume_q + n;
            else
                volume_q = (n >= volume_q) ? 0 : volume_q - n;
        end
        beat.active = 1'b1;
        if (cfg_len_en) begin
            len_acc += 64'(steps);
            if (len_acc > nce_pkg::LEN_MAX)
                len_acc = 64'(nce_pkg::LEN_MAX);
            limit = (longint'(nce_pkg::LEN_STEPS) - cfg_len) * nce_pkg::CPU_HZ_DEF /
                    nce_pkg::LEN_DIV;
            if (len_acc >= limit)
                beat.active = 1'b0;
        end
        mag = 8'(volume_q * 8);
        if (!beat.active)
            beat.sample = '0;
        else
            beat.sample = noise_q ? mag : 8'(-mag);
        beat.noise_bit = noise_q;
        return beat;
    endfunction

    // fill the bits above the register width with random junk
    function automatic t_data with_junk(input int unsigned value,
                                        input int unsigned width);
        t_data junk;
        junk = t_data'($urandom());
        return (junk << width) | t_data'(value);
    endfunction

    function automatic t_steps rand_steps();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_steps'($urandom_range(31));
            default: return t_steps'($urandom_range(4095));
        endcase
    endfunction

    task automatic write_reg(input t_idx idx, input t_data data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            nce_pkg::CFG_DIVIDE_RATIO:    cfg_ratio      = data[2:0];
            nce_pkg::CFG_SHIFT_CLOCK:     cfg_shift      = data[3:0];
            nce_pkg::CFG_WIDE_MODE:       cfg_wide       = data[0];
            nce_pkg::CFG_ENVELOPE_PERIOD: cfg_env_period = data[nce_pkg::ENV_W-1:0];
            nce_pkg::CFG_ENVELOPE_UP:     cfg_env_up     = data[0];
            nce_pkg::CFG_LENGTH_ENABLE:   cfg_len_en     = data[0];
            nce_pkg::CFG_SOUND_LENGTH:    cfg_len        = data[5:0];
            nce_pkg::CFG_START_VOLUME:    cfg_start_vol  = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_step(input t_steps steps);
        int unsigned gap;
        int unsigned r;
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_step_cycles = steps;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(advance_channel(steps));
        items_sent++;
        r   = $urandom_range(99);
        gap = (gaps_off || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_samples.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_reset_state();
        send_step('0);
        send_step(12'd1);
        send_step('1);
        send_step(12'd2048);
        send_step(12'd32);
        settle();
    endtask

    task automatic test_envelope();
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd1);
        write_reg(nce_pkg::CFG_ENVELOPE_UP, with_junk(1, 1));
        send_step('0);
        send_step(12'd20);
        settle();
        write_reg(nce_pkg::CFG_ENVELOPE_UP, with_junk(0, 1));
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'hFFFFFF);
        send_step('1);
        settle();
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd4095);
        send_step('1);
        settle();
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd2);
        send_step('1);
        settle();
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd0);
        send_step(12'd100);
        settle();
    endtask

    task automatic test_short_tap();
        write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd1);
        write_reg(nce_pkg::CFG_ENVELOPE_UP, 24'd1);
        write_reg(nce_pkg::CFG_WIDE_MODE, with_junk(0, 1));
        repeat (3) send_step('1);
        settle();
        write_reg(nce_pkg::CFG_WIDE_MODE, with_junk(1, 1));
    endtask

    // slowest rate builds a backlog that the fastest rate works off at once
    task automatic test_rate_backlog();
        write_reg(nce_pkg::CFG_DIVIDE_RATIO, with_junk(7, 3));
        write_reg(nce_pkg::CFG_SHIFT_CLOCK, with_junk(15, 4));
        repeat (5) send_step('1);
        settle();
        write_reg(nce_pkg::CFG_DIVIDE_RATIO, with_junk(0, 3));
        write_reg(nce_pkg::CFG_SHIFT_CLOCK, with_junk(0, 4));
        send_step(12'd7);
        settle();
    endtask

    task automatic test_register_masking();
        write_reg(CFG_FIRST_UNUSED, t_data'($urandom()));
        write_reg(CFG_LAST_UNUSED, t_data'($urandom()));
        write_reg(nce_pkg::CFG_START_VOLUME, with_junk(15, 4));
        write_reg(nce_pkg::CFG_SOUND_LENGTH, with_junk(63, 6));
        write_reg(nce_pkg::CFG_LENGTH_ENABLE, with_junk(0, 1));
        write_reg(nce_pkg::CFG_DIVIDE_RATIO, with_junk(1, 3));
        send_step('1);
        send_step(12'd55);
        settle();
    endtask

    task automatic test_length_expiry();
        write_reg(nce_pkg::CFG_DIVIDE_RATIO, 24'd0);
        write_reg(nce_pkg::CFG_SOUND_LENGTH, 24'd63);
        write_reg(nce_pkg::CFG_LENGTH_ENABLE, 24'd1);
        repeat (24) send_step(t_steps'($urandom_range(3000, 4095)));
        settle();
        write_reg(nce_pkg::CFG_SOUND_LENGTH, 24'd0);
        repeat (4) send_step(rand_steps());
        settle();
        write_reg(nce_pkg::CFG_SOUND_LENGTH, 24'd63);
        write_reg(nce_pkg::CFG_LENGTH_ENABLE, 24'd0);
        repeat (4) send_step(rand_steps());
        settle();
    endtask

    task automatic test_receiver_hold();
        gaps_off     = 1'b1;
        hold_off_req = 1'b1;
        repeat (16) send_step(rand_steps());
        gaps_off = 1'b0;
        settle();
    endtask

    task automatic test_sender_pause();
        repeat (10) send_step(rand_steps());
        settle();
        repeat (10) send_step(rand_steps());
        settle();
    endtask

    task automatic test_random_phases();
        int unsigned burst;
        while (items_sent < ITEM_TARGET) begin
            settle();
            gaps_off   = ($urandom_range(4) == 0);
            stalls_off = ($urandom_range(4) == 0);
            if ($urandom_range(1))
                write_reg(nce_pkg::CFG_DIVIDE_RATIO, with_junk($urandom_range(7), 3));
            if ($urandom_range(1))
                write_reg(nce_pkg::CFG_SHIFT_CLOCK, with_junk(($urandom_range(4) == 0) ?
                          $urandom_range(15) : $urandom_range(4), 4));
            if ($urandom_range(3) == 0)
                write_reg(nce_pkg::CFG_WIDE_MODE, with_junk($urandom_range(1), 1));
            if ($urandom_range(1)) begin
                case ($urandom_range(5))
                    0:       write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'd0);
                    1, 2:    write_reg(nce_pkg::CFG_ENVELOPE_PERIOD,
                                       t_data'($urandom_range(1, 64)));
                    3, 4:    write_reg(nce_pkg::CFG_ENVELOPE_PERIOD,
                                       t_data'($urandom_range(65, 20000)));
                    default: write_reg(nce_pkg::CFG_ENVELOPE_PERIOD, 24'hFFFFFF);
                endcase
            end
            if ($urandom_range(1))
                write_reg(nce_pkg::CFG_ENVELOPE_UP,
                          with_junk(($urandom_range(4) < 3) ? 1 : 0, 1));
            if ($urandom_range(2) == 0)
                write_reg(nce_pkg::CFG_LENGTH_ENABLE,
                          with_junk(($urandom_range(3) == 0) ? 1 : 0, 1));
            if ($urandom_range(2) == 0)
                write_reg(nce_pkg::CFG_SOUND_LENGTH, with_junk($urandom_range(1) ?
                          $urandom_range(63) : 63, 6));
            if ($urandom_range(4) == 0)
                write_reg(nce_pkg::CFG_START_VOLUME, with_junk($urandom_range(15), 4));
            if ($urandom_range(5) == 0)
                write_reg(t_idx'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                          t_data'($urandom()));
            burst = $urandom_range(15, 50);
            repeat (burst) send_step(rand_steps());
        end
        gaps_off   = 1'b0;
        stalls_off = 1'b0;
        settle();
    endtask

    initial begin
        reset_channel();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_envelope();
        test_short_tap();
        test_rate_backlog();
        test_register_masking();
        test_length_expiry();
        test_receiver_hold();
        test_sender_pause();
        test_random_phases();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
